@@ design/vln_pkg.sv @@
// Package: shared constants for the vector L2 norm block.
`default_nettype none

package vln_pkg;

   // Default accumulator width in bits.
   localparam int ACC_WIDTH_DEF    = 48;
   // Default element width in bits (signed Q8.8 at the default).
   localparam int SAMPLE_WIDTH_DEF = 16;
   // Width of the reported norm, unsigned Q16.8.
   localparam int NORM_WIDTH       = 24;

endpackage : vln_pkg

`default_nettype wire

@@ design/vln_if.sv @@
// Interfaces: element request channel and norm response channel.
`default_nettype none

interface vln_req_if
   import vln_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] element;
   logic                           last;

   modport source (output valid, output element, output last, input ready);
   modport sink   (input valid, input element, input last, output ready);
endinterface : vln_req_if

interface vln_rsp_if
   import vln_pkg::*;
;
   logic                  valid;
   logic                  ready;
   logic [NORM_WIDTH-1:0] norm;
   logic                  saturated;

   modport source (output valid, output norm, output saturated, input ready);
   modport sink   (input valid, input norm, input saturated, output ready);
endinterface : vln_rsp_if

`default_nettype wire

@@ design/vln_square_acc.sv @@
// Square stage and saturating sum-of-squares accumulator.
`default_nettype none

module vln_square_acc
   import vln_pkg::*;
#(
   parameter int ACC_WIDTH    = ACC_WIDTH_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   vln_req_if.sink                   req,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output logic [ACC_WIDTH-1:0]      out_sum,
   output logic                      out_sat
);

   localparam int SQ_W  = 2 * SAMPLE_WIDTH;
   localparam int EXT_W = ((ACC_WIDTH > SQ_W) ? ACC_WIDTH : SQ_W) + 1;
   localparam logic [ACC_WIDTH-1:0] ACC_MAX = '1;

   logic                    sq_valid_ff;
   logic                    sq_valid_in;
   logic [SQ_W-1:0]         sq_ff;
   logic [SQ_W-1:0]         sq_in;
   logic                    last_ff;
   logic                    last_in;
   logic [ACC_WIDTH-1:0]    sum_ff;
   logic [ACC_WIDTH-1:0]    sum_in;
   logic                    sat_ff;
   logic                    sat_in;

   logic [SAMPLE_WIDTH-1:0] mag;
   logic [EXT_W-1:0]        wide_sum;
   logic                    clip;
   logic [ACC_WIDTH-1:0]    next_sum;
   logic                    advance;

   // Magnitude of the element; the most negative code maps to 2^(w-1).
   assign mag   = req.element[SAMPLE_WIDTH-1] ? (~req.element + 1'b1) : req.element;
   assign sq_in = SQ_W'(mag) * SQ_W'(mag);

   assign wide_sum = EXT_W'(sum_ff) + EXT_W'(sq_ff);
   assign clip     = wide_sum > EXT_W'(ACC_MAX);
   assign next_sum = clip ? ACC_MAX : wide_sum[ACC_WIDTH-1:0];

   // A last element waits until the first root cell takes it.
   assign advance   = !sq_valid_ff || !last_ff || out_ready;
   assign req.ready = advance;

   assign out_valid = sq_valid_ff && last_ff;
   assign out_sum   = next_sum;
   assign out_sat   = sat_ff || clip;

   always_comb begin
      sq_valid_in = sq_valid_ff;
      last_in     = last_ff;
      sum_in      = sum_ff;
      sat_in      = sat_ff;
      if (advance) begin
         sq_valid_in = req.valid;
         last_in     = req.last;
         if (sq_valid_ff) begin
            if (last_ff) begin
               sum_in = '0;
               sat_in = 1'b0;
            end else begin
               sum_in = next_sum;
               sat_in = sat_ff || clip;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
         sum_ff      <= '0;
         sat_ff      <= 1'b0;
      end else begin
         sq_valid_ff <= sq_valid_in;
         sum_ff      <= sum_in;
         sat_ff      <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_ff   <= sq_in;
         last_ff <= last_in;
      end
   end

   // The sticky flag is only ever set together with a clipped sum.
   assert property (@(posedge clock) disable iff (reset) sat_ff |-> sum_ff == ACC_MAX)
      else $error("saturation flag set without a clipped sum");

   // Handing a vector to the root chain clears the running state.
   assert property (@(posedge clock) disable iff (reset)
      out_valid && out_ready |=> sum_ff == '0 && !sat_ff)
      else $error("accumulator not cleared after vector end");

   // Within a vector the sum never falls.
   assert property (@(posedge clock) disable iff (reset)
      sq_valid_ff && advance && !last_ff |=> sum_ff >= $past(sum_ff))
      else $error("running sum decreased inside a vector");

endmodule : vln_square_acc

`default_nettype wire

@@ design/vln_sqrt_cell.sv @@
// One cell of the square root chain: resolves one root bit per stage.
`default_nettype none

module vln_sqrt_cell
   import vln_pkg::*;
#(
   parameter int W2      = ACC_WIDTH_DEF,
   parameter int BIT_POS = 0
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire logic [W2-1:0] in_rem,
   input  wire logic [W2-1:0] in_res,
   input  wire logic          in_sat,
   output logic               out_valid,
   input  wire logic          out_ready,
   output logic [W2-1:0]      out_rem,
   output logic [W2-1:0]      out_res,
   output logic               out_sat
);

   localparam logic [W2-1:0] BIT = W2'(1) << BIT_POS;

   logic          valid_ff;
   logic          valid_in;
   logic [W2-1:0] rem_ff;
   logic [W2-1:0] res_ff;
   logic          sat_ff;
   logic          load;
   logic [W2-1:0] trial;

   assign load     = !valid_ff || out_ready;
   assign in_ready = load;
   assign valid_in = load ? in_valid : valid_ff;

   // Try setting this bit; keep it if the remainder covers the trial.
   assign trial = res_ff + BIT;
   always_comb begin
      if (rem_ff >= trial) begin
         out_rem = rem_ff - trial;
         out_res = (res_ff >> 1) + BIT;
      end else begin
         out_rem = rem_ff;
         out_res = res_ff >> 1;
      end
   end

   assign out_valid = valid_ff;
   assign out_sat   = sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff <= in_rem;
         res_ff <= in_res;
         sat_ff <= in_sat;
      end
   end

endmodule : vln_sqrt_cell

`default_nettype wire

@@ design/vector_l2_norm.sv @@
// Top level: streaming Euclidean norm of signed fixed-point vectors.
//
//   channel  dir  payload                      transfer when
//   req      in   element[SAMPLE_WIDTH], last  req_chan.valid && req_chan.ready
//   rsp      out  norm[24], saturated          rsp_chan.valid && rsp_chan.ready
//
// One element transfers per cycle while req is not stalled; the square is registered, then summed.
// A last element waits until the head root cell takes its sum, stalling req.
// One root cell per root bit (24 at the default): after the last element transfers, its
// square is registered and summed, then the sum passes each root cell in turn to rsp.
// Each cell holds its data while the next one is full, so bubbles close up.
// Synchronous active-high reset empties the chain and clears sum and flag.
`default_nettype none

module vector_l2_norm
   import vln_pkg::*;
#(
   parameter int ACC_WIDTH    = ACC_WIDTH_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   vln_req_if.sink   req_chan,
   vln_rsp_if.source rsp_chan
);

   // Root bits and working width of the chain.
   localparam int ROOT_W = (ACC_WIDTH + 1) / 2;
   localparam int W2     = 2 * ROOT_W;

   logic                 acc_valid;
   logic                 acc_ready;
   logic [ACC_WIDTH-1:0] acc_sum;
   logic                 acc_sat;

   logic                 chain_valid [ROOT_W+1];
   logic                 chain_ready [ROOT_W+1];
   logic [W2-1:0]        chain_rem   [ROOT_W+1];
   logic [W2-1:0]        chain_res   [ROOT_W+1];
   logic                 chain_sat   [ROOT_W+1];

   logic [ROOT_W-1:0]    root;

   vln_square_acc #(
      .ACC_WIDTH    (ACC_WIDTH),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_acc (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .out_valid (acc_valid),
      .out_ready (acc_ready),
      .out_sum   (acc_sum),
      .out_sat   (acc_sat)
   );

   // Feed the finished sum into the head of the chain with an empty root.
   assign chain_valid[0] = acc_valid;
   assign acc_ready      = chain_ready[0];
   assign chain_rem[0]   = W2'(acc_sum);
   assign chain_res[0]   = '0;
   assign chain_sat[0]   = acc_sat;

   for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
      vln_sqrt_cell #(
         .W2      (W2),
         .BIT_POS (2 * (ROOT_W - 1 - k))
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_rem    (chain_rem[k]),
         .in_res    (chain_res[k]),
         .in_sat    (chain_sat[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_rem   (chain_rem[k+1]),
         .out_res   (chain_res[k+1]),
         .out_sat   (chain_sat[k+1])
      );
   end

   // The remainder out of the tail cell is not needed.
   assign root = chain_res[ROOT_W][ROOT_W-1:0];

   assign rsp_chan.valid     = chain_valid[ROOT_W];
   assign chain_ready[ROOT_W] = rsp_chan.ready;
   assign rsp_chan.saturated = chain_sat[ROOT_W];

   // Clip the root to the norm field when the accumulator is very wide.
   if (ROOT_W > NORM_WIDTH) begin : g_clip
      assign rsp_chan.norm = (|root[ROOT_W-1:NORM_WIDTH]) ? '1 : root[NORM_WIDTH-1:0];
   end else begin : g_noclip
      assign rsp_chan.norm = NORM_WIDTH'(root);
   end

endmodule : vector_l2_norm

`default_nettype wire
